// ===== design/windowed_byte_rate_meter_top_defines.svh =====
// ----------------------------------------------------------------------------
// Windowed byte rate meter assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_BYTE_RATE_METER_TOP_DEFINES_SVH
`define WINDOWED_BYTE_RATE_METER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check a property outside reset
`define WBRM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// check a property at every edge, reset included
`define WBRM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define WBRM_ASSERT(label, clk, rstn, prop, msg)
`define WBRM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== design/wbrm_pkg.sv =====
// ----------------------------------------------------------------------------
// Windowed byte rate meter package
// Window size, derived widths, sequencer states and divider status.
// ----------------------------------------------------------------------------
package wbrm_pkg;

    localparam int WINDOW_SECONDS = 8;
    // a sum of WINDOW_SECONDS 32-bit totals
    localparam int SUM_W  = 32 + $clog2(WINDOW_SECONDS);
    // 0..WINDOW_SECONDS
    localparam int CNT_W  = $clog2(WINDOW_SECONDS + 1);
    localparam int PTR_W  = (WINDOW_SECONDS > 1) ? $clog2(WINDOW_SECONDS) : 1;
    localparam int STEP_W = $clog2(SUM_W + 1);

    localparam logic [CNT_W-1:0] WINDOW_COUNT = CNT_W'(WINDOW_SECONDS);
    localparam logic [PTR_W-1:0] LAST_SLOT    = PTR_W'(WINDOW_SECONDS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_START,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== design/windowed_byte_rate_meter_top.sv =====
// ----------------------------------------------------------------------------
// Windowed byte rate meter
// Average received bytes per second over the last completed seconds.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready): one transfer per received packet, with
//   its size in bytes and the current time in whole seconds.
//   Output channel (m_valid/m_ready): one transfer per packet, the window sum
//   over the number of completed seconds held, or 0 while none are held.
//   With completed seconds held, an item passes from input transfer to result
//   through the sequencer states in order: PUSH folds the packet into the open
//   second and the ring, START starts the divide, DIV waits for the bit-serial
//   divider to finish, and OUT loads the output register. While no second
//   has been completed the divide is skipped and START goes straight to OUT.
//   s_ready is high only while the sequencer is idle, so a new packet is
//   taken only after the result of the last one is in the output register.
//   The result sits in an output register; a new packet is accepted while it
//   waits, and a stalled receiver holds the sequencer only when the next
//   result is ready and the register is still full.
//   Reset (aresetn low, synchronous) empties the window and closes the open
//   second. The ring of totals needs no clearing pass: an entry is read only
//   after it has been written.
// ----------------------------------------------------------------------------
`include "windowed_byte_rate_meter_top_defines.svh"

module windowed_byte_rate_meter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_packet_bytes,
    input  logic [31:0] s_now_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_bytes_per_second
);
    import wbrm_pkg::*;

    state_t            state_reg, state_next;
    logic [15:0]       bytes_reg, bytes_next;
    logic [31:0]       now_reg, now_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  filled_reg, filled_next;
    logic [PTR_W-1:0]  oldest_reg, oldest_next;
    logic [31:0]       open_sec_reg, open_sec_next;
    logic [31:0]       open_bytes_reg, open_bytes_next;
    logic              open_valid_reg, open_valid_next;
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       m_data_reg, m_data_next;

    logic [31:0]       ring [WINDOW_SECONDS];
    logic [31:0]       rd_data_reg;
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;

    logic [CNT_W:0]    tail_sum;
    logic [PTR_W-1:0]  tail_slot;
    logic [32:0]       sat_sum;
    logic              div_start;
    div_status_t       div_stat;
    logic [SUM_W-1:0]  div_quot;
    logic              out_free;

    wbrm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (filled_reg),
        .status   (div_stat),
        .quotient (div_quot)
    );

    always_comb begin
        tail_sum = {1'b0, CNT_W'(oldest_reg)} + {1'b0, filled_reg};
        if (tail_sum >= (CNT_W + 1)'(WINDOW_SECONDS)) begin
            tail_sum = tail_sum - (CNT_W + 1)'(WINDOW_SECONDS);
        end
        tail_slot = tail_sum[PTR_W-1:0];
        sat_sum   = {1'b0, open_bytes_reg} + {17'b0, bytes_reg};
        out_free  = !m_valid_reg || m_ready;
    end

    always_comb begin
        state_next      = state_reg;
        bytes_next      = bytes_reg;
        now_next        = now_reg;
        sum_next        = sum_reg;
        filled_next     = filled_reg;
        oldest_next     = oldest_reg;
        open_sec_next   = open_sec_reg;
        open_bytes_next = open_bytes_reg;
        open_valid_next = open_valid_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        wr_en           = 1'b0;
        wr_addr         = tail_slot;
        div_start       = 1'b0;
        s_ready         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    bytes_next = s_packet_bytes;
                    now_next   = s_now_seconds;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!open_valid_reg) begin
                    open_valid_next = 1'b1;
                    open_sec_next   = now_reg;
                    open_bytes_next = {16'b0, bytes_reg};
                end else if (now_reg != open_sec_reg) begin
                    wr_en = 1'b1;
                    if (filled_reg == WINDOW_COUNT) begin
                        // evict the oldest total, reuse its slot
                        wr_addr     = oldest_reg;
                        sum_next    = sum_reg - {{(SUM_W - 32){1'b0}}, rd_data_reg}
                                      + {{(SUM_W - 32){1'b0}}, open_bytes_reg};
                        oldest_next = (oldest_reg == LAST_SLOT) ? '0 : oldest_reg + 1'b1;
                    end else begin
                        sum_next    = sum_reg + {{(SUM_W - 32){1'b0}}, open_bytes_reg};
                        filled_next = filled_reg + 1'b1;
                    end
                    open_sec_next   = now_reg;
                    open_bytes_next = {16'b0, bytes_reg};
                end else begin
                    open_bytes_next = sat_sum[32] ? '1 : sat_sum[31:0];
                end
                state_next = ST_START;
            end
            ST_START: begin
                if (filled_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = (filled_reg == '0) ? '0 : div_quot[31:0];
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            sum_reg        <= '0;
            filled_reg     <= '0;
            oldest_reg     <= '0;
            open_sec_reg   <= '0;
            open_bytes_reg <= '0;
            open_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sum_reg        <= sum_next;
            filled_reg     <= filled_next;
            oldest_reg     <= oldest_next;
            open_sec_reg   <= open_sec_next;
            open_bytes_reg <= open_bytes_next;
            open_valid_reg <= open_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        bytes_reg  <= bytes_next;
        now_reg    <= now_next;
        m_data_reg <= m_data_next;
    end

    // ring of completed-second totals
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring[wr_addr] <= open_bytes_reg;
        end
        rd_data_reg <= ring[oldest_reg];
    end

    assign m_valid            = m_valid_reg;
    assign m_bytes_per_second = m_data_reg;

    `WBRM_ASSERT(a_filled_bound, aclk, aresetn, filled_reg <= WINDOW_COUNT, "window count over size")
    `WBRM_ASSERT(a_empty_sum, aclk, aresetn, (filled_reg == '0) |-> (sum_reg == '0), "sum without entries")
    `WBRM_ASSERT(a_done_in_div, aclk, aresetn, div_stat.done |-> (state_reg == ST_DIV), "stray divider done")
    `WBRM_ASSERT(a_start_idle, aclk, aresetn, div_start |-> !div_stat.busy, "divider restarted while busy")
    `WBRM_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> (!m_valid_reg && state_reg == ST_IDLE), "reset left state")

endmodule

// ===== design/wbrm_div.sv =====
// ----------------------------------------------------------------------------
// Windowed byte rate meter divider
// Restoring divider, one quotient bit per cycle, SUM_W bits per quotient.
// ----------------------------------------------------------------------------
module wbrm_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [wbrm_pkg::SUM_W-1:0] dividend,
    input  logic [wbrm_pkg::CNT_W-1:0] divisor,
    output wbrm_pkg::div_status_t     status,
    output logic [wbrm_pkg::SUM_W-1:0] quotient
);
    import wbrm_pkg::*;

    logic [SUM_W-1:0]  quot_reg, quot_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dsr_reg, dsr_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    rem_shift;
    logic [CNT_W:0]    trial;

    always_comb begin
        rem_shift = {rem_reg, quot_reg[SUM_W-1]};
        trial     = rem_shift - {1'b0, dsr_reg};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg) begin
            quot_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            step_next = STEP_W'(SUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // keep the trial remainder when it does not go negative
            if (!trial[CNT_W]) begin
                rem_next  = trial[CNT_W-1:0];
                quot_next = {quot_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_shift[CNT_W-1:0];
                quot_next = {quot_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quot_reg;

endmodule
